>>> design/lbpf_pkg.sv
// shared types, register indexes and constants of the breathing palette fader
// no dependencies
package lbpf_pkg;

  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic       en;
    logic [6:0] speed;
    logic [2:0] pal_size;
  } cfg_t;

  localparam int CFG_IDX_W = 3;
  localparam int COLOR_W   = 24;
  localparam int MUL_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR0 = 3'd2;

  localparam logic [6:0]       SPEED_MAX  = 7'd100;
  localparam logic [6:0]       INTV_BASE  = 7'd100;
  localparam logic [MUL_W-1:0] RECIP_99   = 16'd662;
  localparam logic [MUL_W-1:0] RECIP_100  = 16'd5243;
  localparam logic [31:0]      COLOUR_MS  = 32'd50;

  // quotient of a 9-bit value by 100
  function automatic logic [2:0] div100(input logic [8:0] p);
    logic [2:0] q;
    if (p >= 9'd500) q = 3'd5;
    else if (p >= 9'd400) q = 3'd4;
    else if (p >= 9'd300) q = 3'd3;
    else if (p >= 9'd200) q = 3'd2;
    else if (p >= 9'd100) q = 3'd1;
    else q = 3'd0;
    return q;
  endfunction

  function automatic logic [9:0] times100(input logic [2:0] q);
    logic [9:0] v;
    case (q)
      3'd0: v = 10'd0;
      3'd1: v = 10'd100;
      3'd2: v = 10'd200;
      3'd3: v = 10'd300;
      3'd4: v = 10'd400;
      3'd5: v = 10'd500;
      3'd6: v = 10'd600;
      default: v = 10'd700;
    endcase
    return v;
  endfunction

endpackage

>>> design/led_breathing_palette_fader.sv
// top level: sequencer of the breathing palette fader around one shared multiplier
// depends on lbpf_pkg, lbpf_cfg, lbpf_mul
// Each time word carries the current millisecond count. When the block is enabled
// (speed and palette size nonzero) and a brightness step is due, one color word
// is produced; otherwise the time word is consumed with no result. The single
// 16x16 multiplier serves the interval, blend weight, three blend products and
// three brightness products in turn; with one palette color the blend is skipped.
// in_stall is high while an item is being worked on. A finished result waits in
// the output register and does not hold up the next item until it must be
// replaced.
module led_breathing_palette_fader import lbpf_pkg::*; #(
  parameter int PALETTE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  localparam int IDX_W = (PALETTE_DEPTH > 2) ? 2 : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_IVL, S_CHK, S_COL, S_IDX, S_WGT, S_BMUL, S_BADD, S_SMUL, S_SACC, S_EMIT
  } st_t;

  cfg_t                     cfg;
  rgb_t [PALETTE_DEPTH-1:0] palette;
  logic [MUL_W-1:0]         op_a, op_b;
  logic [2*MUL_W-1:0]       prod;

  st_t         st_r, st_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] last_step_r, last_step_nxt;
  logic [31:0] last_col_r, last_col_nxt;
  logic [7:0]  level_r, level_nxt;
  logic        rising_r, rising_nxt;
  logic [8:0]  prog_r, prog_nxt;
  rgb_t        colour_r, colour_nxt;
  rgb_t        col_a_r, col_a_nxt;
  rgb_t        col_b_r, col_b_nxt;
  logic [8:0]  w1_r, w1_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic        out_valid_r, out_valid_nxt;
  rgb_t        out_r, out_nxt;

  logic [6:0]  spm1;
  logic [13:0] ivl_x;
  logic [6:0]  interval;
  logic [31:0] step_elapsed, col_elapsed;
  logic [8:0]  lvl_sum, prog_inc;
  logic [2:0]  q, i1, i2, t1;
  logic [6:0]  frac;
  logic [1:0]  sel;
  logic [7:0]  ch_a, ch_b, diff, part;

  lbpf_cfg #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .palette   (palette)
  );

  lbpf_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_red   = out_r[2];
  assign out_green = out_r[1];
  assign out_blue  = out_r[0];

  // (speed-1)*95 by shift and add
  assign spm1     = cfg.speed - 7'd1;
  assign ivl_x    = {1'b0, spm1, 6'b0} + {2'b0, spm1, 5'b0} - {7'b0, spm1};
  assign interval = INTV_BASE - prod[22:16];

  assign step_elapsed = now_r - last_step_r;
  assign col_elapsed  = now_r - last_col_r;
  assign lvl_sum      = {1'b0, level_r} + 9'd1;
  assign prog_inc     = prog_r + 9'd1;

  // palette slot and hundredths from progress
  always_comb begin
    q    = div100(prog_r);
    frac = 7'({1'b0, prog_r} - times100(q));
    t1   = (q >= cfg.pal_size) ? q - cfg.pal_size : q;
    i1   = (t1 >= cfg.pal_size) ? t1 - cfg.pal_size : t1;
    i2   = (i1 + 3'd1 == cfg.pal_size) ? 3'd0 : i1 + 3'd1;
  end

  assign sel  = 2'd2 - ch_r;
  assign ch_a = col_a_r[sel];
  assign ch_b = col_b_r[sel];
  assign diff = (ch_b > ch_a) ? ch_b - ch_a : ch_a - ch_b;
  assign part = prod[15:8];

  always_comb begin
    st_nxt        = st_r;
    now_nxt       = now_r;
    last_step_nxt = last_step_r;
    last_col_nxt  = last_col_r;
    level_nxt     = level_r;
    rising_nxt    = rising_r;
    prog_nxt      = prog_r;
    colour_nxt    = colour_r;
    col_a_nxt     = col_a_r;
    col_b_nxt     = col_b_r;
    w1_nxt        = w1_r;
    ch_nxt        = ch_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & out_stall;
    op_a          = '0;
    op_b          = '0;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid && cfg.en) begin
          now_nxt = in_now_ms;
          st_nxt  = S_IVL;
        end
      end
      S_IVL: begin
        op_a   = MUL_W'(ivl_x);
        op_b   = RECIP_99;
        st_nxt = S_CHK;
      end
      S_CHK: begin
        if (step_elapsed < {25'b0, interval}) begin
          st_nxt = S_IDLE;
        end else begin
          last_step_nxt = now_r;
          if (rising_r) begin
            if (lvl_sum >= 9'd255) begin
              level_nxt  = 8'd255;
              rising_nxt = 1'b0;
            end else begin
              level_nxt = lvl_sum[7:0];
            end
          end else if (level_r <= 8'd1) begin
            level_nxt  = 8'd0;
            rising_nxt = 1'b1;
          end else begin
            level_nxt = level_r - 8'd1;
          end
          ch_nxt = 2'd0;
          if (cfg.pal_size == 3'd1) begin
            colour_nxt = palette[0];
            st_nxt     = S_SMUL;
          end else begin
            st_nxt = S_COL;
          end
        end
      end
      S_COL: begin
        if (col_elapsed >= COLOUR_MS) begin
          last_col_nxt = now_r;
          prog_nxt     = ({1'b0, prog_inc} >= times100(cfg.pal_size)) ? 9'd0 : prog_inc;
        end
        st_nxt = S_IDX;
      end
      S_IDX: begin
        col_a_nxt = palette[i1[IDX_W-1:0]];
        col_b_nxt = palette[i2[IDX_W-1:0]];
        op_a      = {1'b0, frac, 8'b0} - {9'b0, frac};
        op_b      = RECIP_100;
        st_nxt    = S_WGT;
      end
      S_WGT: begin
        w1_nxt = {1'b0, prod[26:19]} + 9'd1;
        ch_nxt = 2'd0;
        st_nxt = S_BMUL;
      end
      S_BMUL: begin
        op_a   = MUL_W'(diff);
        op_b   = MUL_W'(w1_r);
        st_nxt = S_BADD;
      end
      S_BADD: begin
        colour_nxt[sel] = (ch_b > ch_a) ? ch_a + part : ch_a - part;
        if (ch_r == 2'd2) begin
          ch_nxt = 2'd0;
          st_nxt = S_SMUL;
        end else begin
          ch_nxt = ch_r + 2'd1;
          st_nxt = S_BMUL;
        end
      end
      S_SMUL: begin
        op_a   = MUL_W'(colour_r[sel]);
        op_b   = MUL_W'(lvl_sum);
        st_nxt = S_SACC;
      end
      S_SACC: begin
        colour_nxt[sel] = part;
        if (ch_r == 2'd2) begin
          st_nxt = S_EMIT;
        end else begin
          ch_nxt = ch_r + 2'd1;
          st_nxt = S_SMUL;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = colour_r;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      last_step_r <= '0;
      last_col_r  <= '0;
      level_r     <= '0;
      rising_r    <= 1'b1;
      prog_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      last_step_r <= last_step_nxt;
      last_col_r  <= last_col_nxt;
      level_r     <= level_nxt;
      rising_r    <= rising_nxt;
      prog_r      <= prog_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r    <= now_nxt;
    colour_r <= colour_nxt;
    col_a_r  <= col_a_nxt;
    col_b_r  <= col_b_nxt;
    w1_r     <= w1_nxt;
    ch_r     <= ch_nxt;
    out_r    <= out_nxt;
  end

endmodule

>>> design/lbpf_cfg.sv
// configuration registers: speed, palette size and palette colours
// depends on lbpf_pkg
module lbpf_cfg import lbpf_pkg::*; #(
  parameter int PALETTE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COLOR_W-1:0]            cfg_data,
  output cfg_t                          cfg,
  output rgb_t [PALETTE_DEPTH-1:0]      palette
);

  logic [6:0]               speed_r;
  logic [2:0]               size_r;
  rgb_t [PALETTE_DEPTH-1:0] palette_r;
  logic                     wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= '0;
      size_r    <= '0;
      palette_r <= '0;
    end else if (wr) begin
      if (cfg_index == REG_SPEED) speed_r <= cfg_data[6:0];
      if (cfg_index == REG_SIZE) size_r <= cfg_data[2:0];
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        if (cfg_index == REG_COLOR0 + CFG_IDX_W'(i)) palette_r[i] <= cfg_data;
      end
    end
  end

  always_comb begin
    cfg.en       = (speed_r != '0) && (size_r != '0);
    cfg.speed    = (speed_r > SPEED_MAX) ? SPEED_MAX : speed_r;
    cfg.pal_size = (size_r > 3'(PALETTE_DEPTH)) ? 3'(PALETTE_DEPTH) : size_r;
  end

  assign palette = palette_r;

endmodule

>>> design/lbpf_mul.sv
// shared multiplier with registered product
// depends on lbpf_pkg
module lbpf_mul import lbpf_pkg::*; (
  input  logic                 clk,
  input  logic [MUL_W-1:0]     op_a,
  input  logic [MUL_W-1:0]     op_b,
  output logic [2*MUL_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

>>> dv/lbpf_checker.sv
// scoreboard of the breathing palette fader: mirrors register writes, predicts each color
// word from the accepted time words and compares the words leaving the block
// depends on lbpf_pkg
module lbpf_checker import lbpf_pkg::*; #(
  parameter int PALETTE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [31:0]          in_now_ms,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           out_red,
  input  logic [7:0]           out_green,
  input  logic [7:0]           out_blue,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  output int unsigned          fail_count,
  output int unsigned          pending,
  output int unsigned          words_checked
);

  localparam int COLORS = 4;

  logic [6:0]         speed_q;
  logic [2:0]         size_q;
  logic [COLOR_W-1:0] palette_q [COLORS];

  logic [31:0] last_step_ms;
  logic [31:0] last_color_ms;
  logic [7:0]  level;
  logic        rising;
  logic [8:0]  progress;

  rgb_t        color_due [$];
  int unsigned errs;
  int unsigned seen;

  function automatic string field_name(input int k);
    case (k)
      2: return "out_red";
      1: return "out_green";
      default: return "out_blue";
    endcase
  endfunction

  // one time word: returns 1 and the scaled color when a brightness step is due
  function automatic bit advance_fader(input logic [31:0] now, output rgb_t word);
    int unsigned sp, sz, intv, i1, i2, frac, wgt, a, b, mix;
    logic [31:0] since;
    rgb_t        base, ca, cb;
    word = '0;
    if (speed_q == 0 || size_q == 0) return 1'b0;
    sp   = (speed_q > SPEED_MAX) ? SPEED_MAX : speed_q;
    sz   = (size_q > PALETTE_DEPTH) ? PALETTE_DEPTH : size_q;
    intv = INTV_BASE - ((sp - 1) * 95) / 99;
    since = now - last_step_ms;
    if (since < intv) return 1'b0;
    last_step_ms = now;

    // triangle ramp 0..255..0
    if (rising) begin
      level = level + 8'd1;
      if (level == 8'd255) rising = 1'b0;
    end else if (level <= 8'd1) begin
      level  = '0;
      rising = 1'b1;
    end else begin
      level = level - 8'd1;
    end

    if (sz == 1) begin
      base = palette_q[0];
    end else begin
      since = now - last_color_ms;
      if (since >= COLOUR_MS) begin
        last_color_ms = now;
        progress = progress + 9'd1;
        if (progress >= sz * 100) progress = '0;
      end
      i1   = (progress / 100) % sz;
      i2   = (i1 + 1) % sz;
      frac = progress % 100;
      wgt  = (frac * 255) / 100;
      ca   = palette_q[2'(i1)];
      cb   = palette_q[2'(i2)];
      for (int k = 0; k < 3; k++) begin
        a = ca[k];
        b = cb[k];
        if (b > a) mix = a + (((b - a) * (wgt + 1)) >> 8);
        else mix = a - (((a - b) * (wgt + 1)) >> 8);
        base[k] = mix[7:0];
      end
    end

    for (int k = 0; k < 3; k++) begin
      mix = (base[k] * (level + 32'd1)) >> 8;
      word[k] = mix[7:0];
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    rgb_t got, want;
    if (!rst_n) begin
      speed_q       = '0;
      size_q        = '0;
      foreach (palette_q[i]) palette_q[i] = '0;
      last_step_ms  = '0;
      last_color_ms = '0;
      level         = '0;
      rising        = 1'b1;
      progress      = '0;
      color_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_red, out_green, out_blue};
        seen++;
        if (color_due.size() == 0) begin
          $error("color word %06h arrived with nothing expected", got);
          errs++;
        end else begin
          want = color_due.pop_front();
          for (int k = 2; k >= 0; k--) begin
            if (got[k] !== want[k]) begin
              $error("%s expected %0d got %0d", field_name(k), want[k], got[k]);
              errs++;
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SPEED) speed_q = cfg_data[6:0];
        else if (cfg_index == REG_SIZE) size_q = cfg_data[2:0];
        else if (cfg_index >= REG_COLOR0 && cfg_index < REG_COLOR0 + COLORS)
          palette_q[2'(cfg_index - REG_COLOR0)] = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (advance_fader(in_now_ms, want)) color_due.push_back(want);
      end
    end
    pending       <= color_due.size();
    fail_count    <= errs;
    words_checked <= seen;
  end

endmodule

>>> dv/led_breathing_palette_fader_test.sv
// testbench top of the breathing palette fader: clock, reset, register setup, time word
// stimulus with random gaps and output stalls, and the final verdict
// depends on lbpf_pkg, led_breathing_palette_fader and lbpf_checker
module led_breathing_palette_fader_test;
  import lbpf_pkg::*;

  localparam int DEPTH  = 4;
  localparam int COLORS = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_COLOR0 + COLORS);

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [31:0]          in_now_ms;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;

  logic [31:0] clock_ms;
  logic [6:0]  cur_speed;
  int unsigned time_words;
  int unsigned reg_writes;
  int unsigned squeeze_req;
  int unsigned squeeze_done;
  bit          no_gaps;

  always #4 clk = ~clk;

  led_breathing_palette_fader #(.PALETTE_DEPTH(DEPTH)) dut (.*);

  lbpf_checker #(.PALETTE_DEPTH(DEPTH)) watch (.*);

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SPEED) cur_speed = data[6:0];
    reg_writes++;
  endtask

  // drain all expected words, then let a word with no result finish
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic offer(input logic [31:0] t);
    int r, gap;
    in_valid  <= 1'b1;
    in_now_ms <= t;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    time_words++;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!no_gaps) begin
      if (r >= 92) gap = $urandom_range(8, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic advance(input logic [31:0] delta);
    clock_ms = clock_ms + delta;
    offer(clock_ms);
  endtask

  // mostly deltas that step, many also moving the color, some too short, some huge
  function automatic logic [31:0] random_delta();
    int unsigned sp, intv, base, r;
    sp   = (cur_speed > SPEED_MAX) ? SPEED_MAX : cur_speed;
    intv = (sp == 0) ? INTV_BASE : INTV_BASE - ((sp - 1) * 95) / 99;
    base = (intv > COLOUR_MS) ? intv : COLOUR_MS;
    r    = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(base, base + 50);
    if (r < 65) return $urandom_range(intv, intv + 49);
    if (r < 85) return $urandom_range(0, intv - 1);
    if (r < 95) return $urandom_range(0, 2000000);
    return $urandom();
  endfunction

  task automatic configure(input logic [6:0] sp, input logic [2:0] sz, input bit noisy);
    logic [COLOR_W-1:0] junk;
    settle();
    junk = COLOR_W'($urandom());
    write_reg(REG_SPEED, noisy ? {junk[23:7], sp} : COLOR_W'(sp));
    junk = COLOR_W'($urandom());
    write_reg(REG_SIZE, noisy ? {junk[23:3], sz} : COLOR_W'(sz));
    for (int k = 0; k < COLORS; k++)
      write_reg(CFG_IDX_W'(REG_COLOR0 + k), COLOR_W'($urandom()));
  endtask

  initial begin : receiver
    int r, len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req != squeeze_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        squeeze_done++;
      end
      out_stall <= 1'b0;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      repeat (len) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 3);
      else if (r < 95) len = $urandom_range(4, 10);
      else len = $urandom_range(20, 80);
      out_stall <= 1'b1;
      repeat (len) @(posedge clk);
    end
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int drain;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_now_ms <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    clock_ms  = '0;
    cur_speed = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset, then speed set but no palette
    offer(clock_ms);
    settle();
    write_reg(REG_SPEED, COLOR_W'(SPEED_MAX));
    advance(32'd10);

    // single white color: short, exact and wrapping time deltas
    settle();
    write_reg(REG_SIZE, 24'd1);
    write_reg(REG_COLOR0, 24'hFFFFFF);
    advance(32'd3);
    advance(32'd4);
    advance(32'd1);
    clock_ms = 32'hFFFF_FFFE;
    offer(clock_ms);
    advance(32'd5);

    // speed beyond range behaves as the fastest
    settle();
    write_reg(REG_SPEED, 24'd127);
    advance(32'd5);
    advance(32'd4);

    // slowest speed, interval boundary
    settle();
    write_reg(REG_SPEED, 24'd1);
    advance(32'd150);
    advance(32'd99);
    advance(32'd1);

    // oversized palette, black to white blend
    settle();
    write_reg(REG_SPEED, COLOR_W'(SPEED_MAX));
    write_reg(REG_SIZE, 24'd7);
    write_reg(REG_COLOR0, 24'h000000);
    write_reg(CFG_IDX_W'(REG_COLOR0 + 1), 24'hFFFFFF);
    write_reg(CFG_IDX_W'(REG_COLOR0 + 2), COLOR_W'($urandom()));
    write_reg(CFG_IDX_W'(REG_COLOR0 + 3), COLOR_W'($urandom()));
    advance(32'd50);
    advance(32'd10);
    advance(32'd45);
    advance(32'd4);
    settle();
    write_reg(REG_SIZE, 24'd2);
    advance(32'd50);
    advance(32'd50);

    // disabled by speed, then by palette size
    settle();
    write_reg(REG_SPEED, 24'd0);
    advance(32'd500);
    settle();
    write_reg(REG_SIZE, 24'd0);
    write_reg(REG_SPEED, 24'd50);
    write_reg(REG_SPARE, COLOR_W'($urandom()));
    advance(32'd500);

    configure(7'd0, 3'd3, 1'b1);
    repeat (20) advance(random_delta());

    // full palette at top speed, first with the output held off
    configure(SPEED_MAX, 3'd4, 1'b0);
    no_gaps = 1'b1;
    squeeze_req++;
    repeat (40) advance(random_delta());
    while (squeeze_done != squeeze_req) advance(random_delta());
    no_gaps = 1'b0;
    repeat (360) advance(random_delta());

    // shrink the palette under a large progress count
    configure(7'd60, 3'd2, 1'b1);
    repeat (150) advance(random_delta());
    configure(7'd97, 3'd7, 1'b1);
    repeat (100) advance(random_delta());
    configure(7'd1, 3'd1, 1'b0);
    repeat (50) advance(random_delta());
    configure(7'($urandom_range(1, 127)), 3'($urandom_range(1, 7)), 1'b1);
    repeat (50) advance(random_delta());

    in_valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (pending != 0) $error("%0d expected color words never arrived", pending);
    $display("run covered %0d time words, %0d color words checked, %0d register writes",
             time_words, words_checked, reg_writes);
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
